/* sv/vdi_pkg.sv */
// Shared types and constants for the vertex dedup indexer.
package vdi_pkg;

  localparam int WORD_W    = 32;
  localparam int NUM_LANES = 8;
  localparam int ROW_W     = (NUM_LANES + 1) * WORD_W;
  localparam int MAG_W     = 31;

  localparam logic [MAG_W-1:0] TOL_RESET = 31'h358637BD;
  localparam logic [MAG_W-1:0] FLOAT_INF = 31'h7F800000;

  typedef struct packed {
    logic              first_of_set;
    logic [WORD_W-1:0] pos_x;
    logic [WORD_W-1:0] pos_y;
    logic [WORD_W-1:0] pos_z;
    logic [WORD_W-1:0] nrm_x;
    logic [WORD_W-1:0] nrm_y;
    logic [WORD_W-1:0] nrm_z;
    logic [WORD_W-1:0] tex_u;
    logic [WORD_W-1:0] tex_v;
    logic [WORD_W-1:0] rgba;
  } vertex_t;

  typedef struct packed {
    logic [7:0] vertex_index;
    logic       is_new;
    logic       overflow;
  } result_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic hit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic issue_done;
    logic pipe_empty;
    logic out_free;
  } status_t;

endpackage

/* sv/vdi_ifs.sv */
// Request and result channel interfaces.
interface vdi_vertex_if;
  import vdi_pkg::*;
  logic    valid;
  logic    ready;
  vertex_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface vdi_result_if;
  import vdi_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* sv/vertex_dedup_indexer.sv */
// Vertex dedup indexer: after a request is accepted, the stored unique vertices (at most
// TABLE_DEPTH) are scanned. One stored entry is read from the entry RAM per cycle and
// checked in all eight float lanes. The lanes form a pipeline (RAM read, align,
// normalize/round), and the scan ends once the pipeline is empty. An emit step follows.
// A match at index k ends the scan early. The emit step waits while the output register
// holds a result that is not taken. One request is handled at a time; a finished result
// waits in the output register while the next request is taken.
module vertex_dedup_indexer #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [vdi_pkg::MAG_W-1:0] cfg_data,
  vdi_vertex_if.sink                vtx,
  vdi_result_if.source              res
);
  import vdi_pkg::*;

  cmd_t    cmd;
  status_t st;

  vdi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vtx.valid),
    .in_ready (vtx.ready),
    .st       (st),
    .cmd      (cmd)
  );

  vdi_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .vtx_data  (vtx.data),
    .res_data  (res.data),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

/* sv/vdi_ram.sv */
// Generic single-port-write, registered-read RAM.
module vdi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/vdi_fdiff.sv */
// One lane: |a - b| in single precision (RNE), flags when it exceeds the tolerance.
module vdi_fdiff (
  input  logic                       clk,
  input  logic [vdi_pkg::WORD_W-1:0] a,
  input  logic [vdi_pkg::WORD_W-1:0] b,
  input  logic [vdi_pkg::MAG_W-1:0]  tol,
  output logic                       fail
);
  import vdi_pkg::*;

  // stage 1: unpack, order, align
  logic [30:0] ma, mb, mx, my;
  logic        a_nan, b_nan, a_inf, b_inf, eff_sub;
  logic [7:0]  exe, eye, dsh;
  logic [23:0] sx, sy;
  logic [26:0] y27, y_shr, y_lost, y_al;

  logic        s1_sub, s1_nan, s1_inf;
  logic [26:0] s1_x, s1_y;
  logic [7:0]  s1_e;

  always_comb begin
    ma      = a[30:0];
    mb      = b[30:0];
    eff_sub = (a[31] == b[31]);
    a_nan   = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan   = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf   = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf   = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    if (mb > ma) begin
      mx = mb;
      my = ma;
    end else begin
      mx = ma;
      my = mb;
    end
    exe = (mx[30:23] == '0) ? 8'd1 : mx[30:23];
    eye = (my[30:23] == '0) ? 8'd1 : my[30:23];
    sx  = {mx[30:23] != '0, mx[22:0]};
    sy  = {my[30:23] != '0, my[22:0]};
    dsh = exe - eye;
    y27 = {sy, 3'b000};
    y_shr  = y27 >> dsh[4:0];
    y_lost = y27 & ~(27'h7FFFFFF << dsh[4:0]);
    if (dsh >= 8'd27) begin
      y_al = {26'd0, |sy};
    end else begin
      y_al = {y_shr[26:1], y_shr[0] | (|y_lost)};
    end
  end

  always_ff @(posedge clk) begin
    s1_x   <= {sx, 3'b000};
    s1_y   <= y_al;
    s1_e   <= exe;
    s1_sub <= eff_sub;
    s1_nan <= a_nan | b_nan | (a_inf & b_inf & eff_sub);
    s1_inf <= a_inf | b_inf;
  end

  // stage 2: add or subtract, normalize
  logic [27:0] sum;
  logic [26:0] dif, r;
  logic [8:0]  e, ef;
  logic [4:0]  lz, sh;
  logic [26:0] s2_r;
  logic [8:0]  s2_ef;
  logic        s2_nan, s2_inf;

  always_comb begin
    sum = {1'b0, s1_x} + {1'b0, s1_y};
    dif = s1_x - s1_y;
    lz  = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (dif[i]) begin
        lz = 5'(26 - i);
      end
    end
    sh = '0;
    if (s1_sub) begin
      if ({4'd0, lz} < ({1'b0, s1_e} - 9'd1)) begin
        sh = lz;
      end else begin
        sh = 5'({1'b0, s1_e} - 9'd1);
      end
      r = dif << sh;
      e = {1'b0, s1_e} - {4'd0, sh};
    end else if (sum[27]) begin
      r = {sum[27:2], sum[1] | sum[0]};
      e = {1'b0, s1_e} + 9'd1;
    end else begin
      r = sum[26:0];
      e = {1'b0, s1_e};
    end
    ef = r[26] ? e : 9'd0;
  end

  always_ff @(posedge clk) begin
    s2_r   <= r;
    s2_ef  <= ef;
    s2_nan <= s1_nan;
    s2_inf <= s1_inf;
  end

  // round and compare
  logic        up;
  logic [30:0] mag;

  always_comb begin
    up = s2_r[2] & (s2_r[1] | s2_r[0] | s2_r[3]);
    if (s2_inf || s2_ef >= 9'd255) begin
      mag = FLOAT_INF;
    end else begin
      mag = {s2_ef[7:0], s2_r[25:3]} + {30'd0, up};
    end
    fail = !s2_nan && (mag > tol);
  end

endmodule

/* sv/vdi_datapath.sv */
// Datapath: vertex and tolerance registers, entry RAM, compare lanes, result register.
module vdi_datapath #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [vdi_pkg::MAG_W-1:0] cfg_data,
  input  vdi_pkg::vertex_t          vtx_data,
  output vdi_pkg::result_t          res_data,
  output logic                      res_valid,
  input  logic                      res_ready,
  input  vdi_pkg::cmd_t             cmd,
  output vdi_pkg::status_t          st
);
  import vdi_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  logic [MAG_W-1:0] tol;
  vertex_t          vtx;
  logic [CW-1:0]    count, issue_cnt;
  logic             v1, v2, v3, ceq1, ceq2, found;
  logic [IW-1:0]    k1, k2, k3, found_idx;
  logic [ROW_W-1:0] rdata, wdata;
  logic [WORD_W-1:0] comp [NUM_LANES];
  logic [NUM_LANES-1:0] lane_fail;
  logic             full, we;
  logic [IW+7:0]    hit_ext, new_ext;

  assign comp[0] = vtx.pos_x;
  assign comp[1] = vtx.pos_y;
  assign comp[2] = vtx.pos_z;
  assign comp[3] = vtx.nrm_x;
  assign comp[4] = vtx.nrm_y;
  assign comp[5] = vtx.nrm_z;
  assign comp[6] = vtx.tex_u;
  assign comp[7] = vtx.tex_v;

  assign wdata = {vtx.rgba, vtx.tex_v, vtx.tex_u, vtx.nrm_z, vtx.nrm_y, vtx.nrm_x,
                  vtx.pos_z, vtx.pos_y, vtx.pos_x};
  assign full  = (count == FULL);
  assign we    = cmd.finish && !found && !full;

  vdi_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (count[IW-1:0]),
    .wdata (wdata),
    .re    (cmd.issue),
    .raddr (issue_cnt[IW-1:0]),
    .rdata (rdata)
  );

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    vdi_fdiff u_lane (
      .clk  (clk),
      .a    (comp[g]),
      .b    (rdata[g*WORD_W +: WORD_W]),
      .tol  (tol),
      .fail (lane_fail[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_we) begin
      tol <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vtx <= vtx_data;
    end
    ceq1 <= (rdata[NUM_LANES*WORD_W +: WORD_W] == vtx.rgba);
    ceq2 <= ceq1;
    k1   <= issue_cnt[IW-1:0];
    k2   <= k1;
    k3   <= k2;
    if (cmd.hit) begin
      found_idx <= k3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      issue_cnt <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (cmd.load) begin
        issue_cnt <= '0;
        v1        <= 1'b0;
        v2        <= 1'b0;
        v3        <= 1'b0;
        found     <= 1'b0;
        if (vtx_data.first_of_set) begin
          count <= '0;
        end
      end else begin
        v1 <= cmd.issue;
        v2 <= v1;
        v3 <= v2;
        if (cmd.issue) begin
          issue_cnt <= issue_cnt + 1'b1;
        end
        if (cmd.hit) begin
          found <= 1'b1;
        end
        if (we) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  assign hit_ext = {8'd0, found_idx};
  assign new_ext = {8'd0, count[IW-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (found) begin
        res_data <= '{vertex_index: hit_ext[7:0], is_new: 1'b0, overflow: 1'b0};
      end else if (full) begin
        res_data <= '{vertex_index: 8'd0, is_new: 1'b0, overflow: 1'b1};
      end else begin
        res_data <= '{vertex_index: new_ext[7:0], is_new: 1'b1, overflow: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  assign st.match      = v3 && !(|lane_fail) && ceq2;
  assign st.issue_done = (issue_cnt == count);
  assign st.pipe_empty = !v1 && !v2 && !v3;
  assign st.out_free   = !res_valid || res_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL) else $error("entry count above table depth");
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> issue_cnt < count) else $error("read past stored entries");
  a_append: assert property (@(posedge clk) disable iff (rst)
    we |=> count == $past(count) + 1'b1) else $error("append did not bump count");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_data.is_new && res_data.overflow)) else $error("new and overflow");

endmodule

/* sv/vdi_ctrl.sv */
// Controller: accept, scan, emit sequencing.
module vdi_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vdi_pkg::status_t st,
  output vdi_pkg::cmd_t    cmd
);
  import vdi_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.match) begin
          cmd.hit    = 1'b1;
          state_next = S_EMIT;
        end else if (st.issue_done && st.pipe_empty) begin
          state_next = S_EMIT;
        end else begin
          cmd.issue = !st.issue_done;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_hit_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.hit |=> state == S_EMIT) else $error("hit did not lead to emit");
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == S_IDLE) else $error("finish did not return to idle");

endmodule
